// ===== hdl/i2c_transaction_sequencer_assert.svh =====
// assertion macros for the transaction sequencer checks
`ifndef I2C_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_TRANSACTION_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define ITS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sequencer check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define ITS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sequencer check failed");

`endif

// ===== hdl/its_pkg.sv =====
package its_pkg;

   // buffer geometry
   localparam int BUF_DEPTH = 256;
   localparam int SLOT_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int SEL_W     = 2;
   localparam int RAM_AW    = SEL_W + SLOT_W;
   localparam int RAM_DEPTH = 1 << RAM_AW;
   localparam int BYTE_W    = 8;
   localparam int SIZE_W    = 9;
   localparam int CSR_IDX_W = 1;
   localparam int IDX_SPAN  = 256;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef slot_type slot_table_type [IDX_SPAN];

   // byte index to store slot, index modulo the buffer depth
   function automatic slot_table_type build_slot_table();
      slot_table_type t;
      for (int i = 0; i < IDX_SPAN; i++) begin
         t[i] = SLOT_W'(i % BUF_DEPTH);
      end
      return t;
   endfunction

   localparam slot_table_type SLOT_TABLE = build_slot_table();

   // command codes
   localparam logic [2:0] CMD_START_WR = 3'd0;
   localparam logic [2:0] CMD_START_RD = 3'd1;
   localparam logic [2:0] CMD_STATUS   = 3'd2;
   localparam logic [2:0] CMD_LOAD     = 3'd3;
   localparam logic [2:0] CMD_READ     = 3'd4;

   // control actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_ACK     = 3'd1;
   localparam logic [2:0] ACT_NACK    = 3'd2;
   localparam logic [2:0] ACT_START   = 3'd3;
   localparam logic [2:0] ACT_RESTART = 3'd4;
   localparam logic [2:0] ACT_STOP    = 3'd5;

   // store selects
   localparam logic [SEL_W-1:0] SEL_MASTER_TX = 2'd0;
   localparam logic [SEL_W-1:0] SEL_MASTER_RX = 2'd1;
   localparam logic [SEL_W-1:0] SEL_SLAVE_TX  = 2'd2;
   localparam logic [SEL_W-1:0] SEL_SLAVE_RX  = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_TX_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_RX_SIZE = 1'd1;

   // bus status codes, divided by eight
   localparam logic [4:0] ST_START       = 5'h01;  // 0x08
   localparam logic [4:0] ST_RESTART     = 5'h02;  // 0x10
   localparam logic [4:0] ST_MT_SLA_ACK  = 5'h03;  // 0x18
   localparam logic [4:0] ST_MT_DATA_ACK = 5'h05;  // 0x28
   localparam logic [4:0] ST_ARB_LOST    = 5'h07;  // 0x38
   localparam logic [4:0] ST_MR_SLA_ACK  = 5'h08;  // 0x40
   localparam logic [4:0] ST_MR_DATA_ACK = 5'h0A;  // 0x50
   localparam logic [4:0] ST_MR_DATA_NAK = 5'h0B;  // 0x58
   localparam logic [4:0] ST_SR_SLA_0    = 5'h0C;  // 0x60
   localparam logic [4:0] ST_SR_SLA_1    = 5'h0D;  // 0x68
   localparam logic [4:0] ST_SR_GEN_0    = 5'h0E;  // 0x70
   localparam logic [4:0] ST_SR_GEN_1    = 5'h0F;  // 0x78
   localparam logic [4:0] ST_SR_DATA     = 5'h10;  // 0x80
   localparam logic [4:0] ST_SR_GEN_DATA = 5'h12;  // 0x90
   localparam logic [4:0] ST_SR_STOP     = 5'h14;  // 0xA0
   localparam logic [4:0] ST_ST_SLA      = 5'h15;  // 0xA8
   localparam logic [4:0] ST_ST_ARB_SLA  = 5'h16;  // 0xB0
   localparam logic [4:0] ST_ST_DATA_ACK = 5'h17;  // 0xB8
   localparam logic [4:0] ST_ST_DATA_NAK = 5'h18;  // 0xC0
   localparam logic [4:0] ST_ST_LAST     = 5'h19;  // 0xC8

   // result of the decode stage, waiting for the store read data
   typedef struct packed {
      logic [2:0]        act;
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              busy;
      logic              master_done;
      logic              slave_done;
      logic              error;
      logic              tx_from_ram;
      logic              rd_from_ram;
   } stage_type;

endpackage

// ===== hdl/its_ram.sv =====
module its_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/its_ctrl.sv =====
module its_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  logic [2:0]                          req_cmd,
   input  logic [6:0]                          req_target_addr,
   input  logic [7:0]                          req_reg_addr,
   input  logic [7:0]                          req_xfer_length,
   input  logic [4:0]                          req_status_code,
   input  logic [7:0]                          req_rx_byte,
   input  logic [its_pkg::SEL_W-1:0]           req_buf_select,
   input  logic [7:0]                          req_buf_index,
   input  logic [7:0]                          req_buf_data,
   input  logic                                csr_wr_en,
   input  logic [its_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [its_pkg::SIZE_W-1:0]          csr_wdata,
   output logic                                ram_en,
   output logic                                ram_we,
   output logic [its_pkg::RAM_AW-1:0]          ram_addr,
   output logic [its_pkg::BYTE_W-1:0]          ram_wdata,
   output its_pkg::stage_type                  stage
);

   logic [its_pkg::SIZE_W-1:0] tx_size_ff, rx_size_ff;
   logic       busy_ff, busy_in;
   logic [7:0] index_ff, index_in;
   logic       expect_ff, expect_in;
   logic [7:0] addr_rw_ff, addr_rw_in;
   logic [7:0] target_reg_ff, target_reg_in;
   logic [7:0] remain_ff, remain_in;
   logic       ram_access;
   logic [7:0] index_inc;

   // index step that wraps at a configured size
   function automatic logic [7:0] advance_wrap(input logic [7:0] idx,
                                               input logic [its_pkg::SIZE_W-1:0] size);
      logic [its_pkg::SIZE_W-1:0] n;
      n = {1'b0, idx + 8'd1};
      if (n >= size) begin
         n = n - size;
      end
      return n[7:0];
   endfunction

   assign index_inc = index_ff + 8'd1;

   // decode one word against the current sequencer state
   always_comb begin
      busy_in       = busy_ff;
      index_in      = index_ff;
      expect_in     = expect_ff;
      addr_rw_in    = addr_rw_ff;
      target_reg_in = target_reg_ff;
      remain_in     = remain_ff;
      ram_access    = 1'b0;
      ram_we        = 1'b0;
      ram_addr      = {req_buf_select, its_pkg::SLOT_TABLE[req_buf_index]};
      ram_wdata     = req_buf_data;
      stage         = '0;
      stage.act     = its_pkg::ACT_NONE;
      case (req_cmd)
         its_pkg::CMD_START_WR, its_pkg::CMD_START_RD: begin
            busy_in       = 1'b1;
            addr_rw_in    = {req_target_addr, req_cmd == its_pkg::CMD_START_RD};
            target_reg_in = req_reg_addr;
            remain_in     = (req_cmd == its_pkg::CMD_START_RD && req_xfer_length == 8'd0)
                            ? 8'd1 : req_xfer_length;
            stage.act     = its_pkg::ACT_START;
         end
         its_pkg::CMD_LOAD: begin
            ram_access = 1'b1;
            ram_we     = 1'b1;
         end
         its_pkg::CMD_READ: begin
            ram_access        = 1'b1;
            stage.rd_from_ram = 1'b1;
         end
         its_pkg::CMD_STATUS: begin
            case (req_status_code)
               its_pkg::ST_SR_SLA_0, its_pkg::ST_SR_SLA_1,
               its_pkg::ST_SR_GEN_0, its_pkg::ST_SR_GEN_1: begin
                  busy_in   = 1'b1;
                  expect_in = 1'b1;
                  stage.act = its_pkg::ACT_ACK;
               end
               its_pkg::ST_SR_DATA, its_pkg::ST_SR_GEN_DATA: begin
                  if (expect_ff) begin
                     index_in  = req_rx_byte;
                     expect_in = 1'b0;
                  end else begin
                     ram_access = 1'b1;
                     ram_we     = 1'b1;
                     ram_addr   = {its_pkg::SEL_SLAVE_RX, its_pkg::SLOT_TABLE[index_ff]};
                     ram_wdata  = req_rx_byte;
                     index_in   = advance_wrap(index_ff, rx_size_ff);
                  end
                  stage.act = its_pkg::ACT_ACK;
               end
               its_pkg::ST_SR_STOP: begin
                  busy_in          = 1'b0;
                  stage.slave_done = 1'b1;
                  stage.act        = its_pkg::ACT_ACK;
               end
               its_pkg::ST_ST_SLA, its_pkg::ST_ST_ARB_SLA, its_pkg::ST_ST_DATA_ACK: begin
                  busy_in           = 1'b1;
                  ram_access        = 1'b1;
                  ram_addr          = {its_pkg::SEL_SLAVE_TX, its_pkg::SLOT_TABLE[index_ff]};
                  stage.tx_valid    = 1'b1;
                  stage.tx_from_ram = 1'b1;
                  index_in          = advance_wrap(index_ff, tx_size_ff);
                  stage.act         = its_pkg::ACT_ACK;
               end
               its_pkg::ST_ST_DATA_NAK, its_pkg::ST_ST_LAST: begin
                  stage.act = its_pkg::ACT_ACK;
               end
               its_pkg::ST_START: begin
                  busy_in        = 1'b1;
                  index_in       = 8'd0;
                  stage.tx_valid = 1'b1;
                  stage.tx_byte  = {addr_rw_ff[7:1], 1'b0};
                  stage.act      = its_pkg::ACT_ACK;
               end
               its_pkg::ST_RESTART: begin
                  stage.tx_valid = 1'b1;
                  stage.tx_byte  = addr_rw_ff;
                  index_in       = 8'd0;
                  if (remain_ff != 8'd0) begin
                     remain_in = remain_ff - 8'd1;
                  end
                  stage.act = its_pkg::ACT_ACK;
               end
               its_pkg::ST_MT_SLA_ACK: begin
                  stage.tx_valid = 1'b1;
                  stage.tx_byte  = target_reg_ff;
                  stage.act      = its_pkg::ACT_ACK;
               end
               its_pkg::ST_MT_DATA_ACK: begin
                  if (addr_rw_ff[0]) begin
                     stage.act = its_pkg::ACT_RESTART;
                  end else if (index_ff >= remain_ff) begin
                     stage.act         = its_pkg::ACT_STOP;
                     busy_in           = 1'b0;
                     stage.master_done = 1'b1;
                  end else begin
                     ram_access        = 1'b1;
                     ram_addr          = {its_pkg::SEL_MASTER_TX,
                                          its_pkg::SLOT_TABLE[index_ff]};
                     stage.tx_valid    = 1'b1;
                     stage.tx_from_ram = 1'b1;
                     index_in          = index_inc;
                     stage.act         = its_pkg::ACT_ACK;
                  end
               end
               its_pkg::ST_MR_SLA_ACK: begin
                  stage.act = (index_ff >= remain_ff) ? its_pkg::ACT_NACK : its_pkg::ACT_ACK;
               end
               its_pkg::ST_MR_DATA_ACK: begin
                  ram_access = 1'b1;
                  ram_we     = 1'b1;
                  ram_addr   = {its_pkg::SEL_MASTER_RX, its_pkg::SLOT_TABLE[index_ff]};
                  ram_wdata  = req_rx_byte;
                  index_in   = index_inc;
                  stage.act  = (index_inc >= remain_ff) ? its_pkg::ACT_NACK : its_pkg::ACT_ACK;
               end
               its_pkg::ST_MR_DATA_NAK: begin
                  ram_access        = 1'b1;
                  ram_we            = 1'b1;
                  ram_addr          = {its_pkg::SEL_MASTER_RX, its_pkg::SLOT_TABLE[index_ff]};
                  ram_wdata         = req_rx_byte;
                  index_in          = index_inc;
                  stage.act         = its_pkg::ACT_STOP;
                  busy_in           = 1'b0;
                  stage.master_done = 1'b1;
               end
               its_pkg::ST_ARB_LOST: begin
                  stage.act = its_pkg::ACT_ACK;
                  busy_in   = 1'b0;
               end
               default: begin
                  stage.act   = its_pkg::ACT_STOP;
                  busy_in     = 1'b0;
                  stage.error = 1'b1;
               end
            endcase
         end
         default: begin
         end
      endcase
      stage.busy = busy_in;
   end

   assign ram_en = fire & ram_access;

   // sequencer state, updated once per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         index_ff      <= 8'd0;
         expect_ff     <= 1'b0;
         addr_rw_ff    <= 8'd0;
         target_reg_ff <= 8'd0;
         remain_ff     <= 8'd0;
      end else if (fire) begin
         busy_ff       <= busy_in;
         index_ff      <= index_in;
         expect_ff     <= expect_in;
         addr_rw_ff    <= addr_rw_in;
         target_reg_ff <= target_reg_in;
         remain_ff     <= remain_in;
      end
   end

   // buffer size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_size_ff <= '0;
         rx_size_ff <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == its_pkg::CSR_SLAVE_TX_SIZE) begin
            tx_size_ff <= csr_wdata;
         end
         if (csr_index == its_pkg::CSR_SLAVE_RX_SIZE) begin
            rx_size_ff <= csr_wdata;
         end
      end
   end

endmodule

// ===== hdl/its_out.sv =====
module its_out (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  its_pkg::stage_type          stage,
   input  logic [its_pkg::BYTE_W-1:0]  ram_rdata,
   output logic                        ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_ctrl_action,
   output logic                        rsp_tx_valid,
   output logic [7:0]                  rsp_tx_byte,
   output logic                        rsp_busy_res,
   output logic                        rsp_master_done,
   output logic                        rsp_slave_done,
   output logic                        rsp_error_pulse,
   output logic [7:0]                  rsp_read_data
);

   logic               s1_valid_ff, s1_valid_in;
   its_pkg::stage_type s1_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               advance;
   logic [2:0]         act_ff;
   logic               txv_ff, busy_ff, mdone_ff, sdone_ff, err_ff;
   logic [7:0]         txb_ff, rd_ff;

   // stage one moves on when the output register is free or being emptied
   assign advance      = !rsp_valid_ff || rsp_ready;
   assign ready        = !s1_valid_ff || advance;
   assign s1_valid_in  = fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // decode result waits here for the store read data
   always_ff @(posedge clock) begin
      if (fire) begin
         s1_ff <= stage;
      end
   end

   // output register, store data merged in
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         act_ff   <= s1_ff.act;
         txv_ff   <= s1_ff.tx_valid;
         txb_ff   <= s1_ff.tx_from_ram ? ram_rdata : s1_ff.tx_byte;
         busy_ff  <= s1_ff.busy;
         mdone_ff <= s1_ff.master_done;
         sdone_ff <= s1_ff.slave_done;
         err_ff   <= s1_ff.error;
         rd_ff    <= s1_ff.rd_from_ram ? ram_rdata : 8'd0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ctrl_action = act_ff;
   assign rsp_tx_valid    = txv_ff;
   assign rsp_tx_byte     = txb_ff;
   assign rsp_busy_res    = busy_ff;
   assign rsp_master_done = mdone_ff;
   assign rsp_slave_done  = sdone_ff;
   assign rsp_error_pulse = err_ff;
   assign rsp_read_data   = rd_ff;

endmodule

// ===== hdl/i2c_transaction_sequencer.sv =====
// an accepted word waits in the stage-one register for its store read data, then moves
// to the output register; throughput: one word per cycle while results are taken, as
// req_ready drops when both registers are full and rsp_ready is low; each word makes
// at most one access to the single-port byte store (all four buffers share it), so no
// interlock is needed; reset: clears sequencer state, buffer sizes and the pipeline
// valid flags; buffer contents stay undefined until loaded
module i2c_transaction_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_cmd,
   input  logic [6:0]                        req_target_addr,
   input  logic [7:0]                        req_reg_addr,
   input  logic [7:0]                        req_xfer_length,
   input  logic [4:0]                        req_status_code,
   input  logic [7:0]                        req_rx_byte,
   input  logic [1:0]                        req_buf_select,
   input  logic [7:0]                        req_buf_index,
   input  logic [7:0]                        req_buf_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_ctrl_action,
   output logic                              rsp_tx_valid,
   output logic [7:0]                        rsp_tx_byte,
   output logic                              rsp_busy_res,
   output logic                              rsp_master_done,
   output logic                              rsp_slave_done,
   output logic                              rsp_error_pulse,
   output logic [7:0]                        rsp_read_data,
   input  logic                              csr_wr_en,
   input  logic [its_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [its_pkg::SIZE_W-1:0]        csr_wdata
);

   logic                           fire;
   logic                           ram_en, ram_we;
   logic [its_pkg::RAM_AW-1:0]     ram_addr;
   logic [its_pkg::BYTE_W-1:0]     ram_wdata, ram_rdata;
   its_pkg::stage_type             stage;

   assign fire = req_valid & req_ready;

   // decode and sequencer state
   its_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .req_cmd         (req_cmd),
      .req_target_addr (req_target_addr),
      .req_reg_addr    (req_reg_addr),
      .req_xfer_length (req_xfer_length),
      .req_status_code (req_status_code),
      .req_rx_byte     (req_rx_byte),
      .req_buf_select  (req_buf_select),
      .req_buf_index   (req_buf_index),
      .req_buf_data    (req_buf_data),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .ram_en          (ram_en),
      .ram_we          (ram_we),
      .ram_addr        (ram_addr),
      .ram_wdata       (ram_wdata),
      .stage           (stage)
   );

   // four byte buffers in one store, addressed by select and slot
   its_ram #(
      .WIDTH (its_pkg::BYTE_W),
      .DEPTH (its_pkg::RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // read data merge and output register
   its_out u_out (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .stage           (stage),
      .ram_rdata       (ram_rdata),
      .ready           (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ctrl_action (rsp_ctrl_action),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_master_done (rsp_master_done),
      .rsp_slave_done  (rsp_slave_done),
      .rsp_error_pulse (rsp_error_pulse),
      .rsp_read_data   (rsp_read_data)
   );

endmodule

// ===== hdl/its_checker.sv =====
`include "i2c_transaction_sequencer_assert.svh"

module its_assert_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_ctrl_action,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_busy_res,
   input logic       rsp_master_done,
   input logic       rsp_slave_done,
   input logic       rsp_error_pulse,
   input logic [7:0] rsp_read_data
);

   // a stalled result word holds
   `ITS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ctrl_action) && $stable(rsp_tx_byte) && $stable(rsp_read_data))

   // no byte shown without a send request
   `ITS_ASSERT_NOW(a_tx_zero, rsp_valid && !rsp_tx_valid, rsp_tx_byte == 8'd0)

   // master completion and errors stop the bus and leave the block idle
   `ITS_ASSERT_NOW(a_end_stop, rsp_valid && (rsp_master_done || rsp_error_pulse), rsp_ctrl_action == its_pkg::ACT_STOP && !rsp_busy_res && !rsp_slave_done)

   // buffer read-back carries no bus action
   `ITS_ASSERT_NOW(a_read_quiet, rsp_valid && rsp_read_data != 8'd0, rsp_ctrl_action == its_pkg::ACT_NONE && !rsp_tx_valid && $countones({rsp_master_done, rsp_slave_done, rsp_error_pulse}) == 0)

endmodule

bind i2c_transaction_sequencer its_assert_checker u_its_assert_checker (.*);

// ===== dv/its_checker.sv =====
// watches both channels and the size registers, predicts every response word
// and compares it field by field with what the sequencer returns
module its_checker
   import its_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [2:0]           req_cmd,
   input  logic [6:0]           req_target_addr,
   input  logic [7:0]           req_reg_addr,
   input  logic [7:0]           req_xfer_length,
   input  logic [4:0]           req_status_code,
   input  logic [7:0]           req_rx_byte,
   input  logic [1:0]           req_buf_select,
   input  logic [7:0]           req_buf_index,
   input  logic [7:0]           req_buf_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [2:0]           rsp_ctrl_action,
   input  logic                 rsp_tx_valid,
   input  logic [7:0]           rsp_tx_byte,
   input  logic                 rsp_busy_res,
   input  logic                 rsp_master_done,
   input  logic                 rsp_slave_done,
   input  logic                 rsp_error_pulse,
   input  logic [7:0]           rsp_read_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata,
   output int                   fail_count,
   output int                   pending_count
);

   typedef struct packed {
      logic [2:0] cmd;
      logic [6:0] target_addr;
      logic [7:0] reg_addr;
      logic [7:0] xfer_length;
      logic [4:0] status_code;
      logic [7:0] rx_byte;
      logic [1:0] buf_select;
      logic [7:0] buf_index;
      logic [7:0] buf_data;
   } bus_request_type;

   typedef struct packed {
      logic [2:0] ctrl_action;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       busy_res;
      logic       master_done;
      logic       slave_done;
      logic       error_pulse;
      logic [7:0] read_data;
   } bus_response_type;

   // predicted sequencer state
   logic [SIZE_W-1:0] tx_wrap;
   logic [SIZE_W-1:0] rx_wrap;
   logic              busy_q;
   logic [7:0]        byte_idx;
   logic              index_pending;
   logic [7:0]        addr_rw;
   logic [7:0]        reg_q;
   logic [7:0]        left_q;
   logic [7:0]        byte_store [4][BUF_DEPTH];

   bus_response_type expected_responses[$];
   int               errors = 0;

   // slave index step, folded back once at the configured size
   function automatic logic [7:0] wrap_next(input logic [7:0] idx, input logic [SIZE_W-1:0] size);
      int n;
      n = (int'(idx) + 1) & 8'hFF;
      if (n >= int'(size)) n -= int'(size);
      return 8'(n);
   endfunction

   // advances the predicted state by one request word, returns its response word
   function automatic bus_response_type sequencer_response(input bus_request_type w);
      bus_response_type r;
      r = '0;
      r.ctrl_action = ACT_NONE;
      case (w.cmd)
         CMD_START_WR, CMD_START_RD: begin
            busy_q = 1'b1;
            addr_rw = {w.target_addr, w.cmd[0]};
            reg_q = w.reg_addr;
            left_q = (w.cmd == CMD_START_RD && w.xfer_length == 0) ? 8'd1 : w.xfer_length;
            r.ctrl_action = ACT_START;
         end
         CMD_LOAD: begin
            byte_store[w.buf_select][w.buf_index % BUF_DEPTH] = w.buf_data;
         end
         CMD_READ: begin
            r.read_data = byte_store[w.buf_select][w.buf_index % BUF_DEPTH];
         end
         CMD_STATUS: begin
            r.ctrl_action = ACT_ACK;
            case (w.status_code)
               // slave addressed for write, first data word is the index
               ST_SR_SLA_0, ST_SR_SLA_1, ST_SR_GEN_0, ST_SR_GEN_1: begin
                  busy_q = 1'b1;
                  index_pending = 1'b1;
               end
               ST_SR_DATA, ST_SR_GEN_DATA: begin
                  if (index_pending) begin
                     byte_idx = w.rx_byte;
                     index_pending = 1'b0;
                  end else begin
                     byte_store[SEL_SLAVE_RX][byte_idx % BUF_DEPTH] = w.rx_byte;
                     byte_idx = wrap_next(byte_idx, rx_wrap);
                  end
               end
               ST_SR_STOP: begin
                  busy_q = 1'b0;
                  r.slave_done = 1'b1;
               end
               // slave transmit drains the slave tx buffer
               ST_ST_SLA, ST_ST_ARB_SLA, ST_ST_DATA_ACK: begin
                  busy_q = 1'b1;
                  r.tx_valid = 1'b1;
                  r.tx_byte = byte_store[SEL_SLAVE_TX][byte_idx % BUF_DEPTH];
                  byte_idx = wrap_next(byte_idx, tx_wrap);
               end
               ST_ST_DATA_NAK, ST_ST_LAST: begin
               end
               // master side: address with write bit after start
               ST_START: begin
                  busy_q = 1'b1;
                  byte_idx = '0;
                  r.tx_valid = 1'b1;
                  r.tx_byte = {addr_rw[7:1], 1'b0};
               end
               ST_RESTART: begin
                  r.tx_valid = 1'b1;
                  r.tx_byte = addr_rw;
                  byte_idx = '0;
                  if (left_q != 0) left_q = left_q - 8'd1;
               end
               ST_MT_SLA_ACK: begin
                  r.tx_valid = 1'b1;
                  r.tx_byte = reg_q;
               end
               ST_MT_DATA_ACK: begin
                  if (addr_rw[0]) begin
                     r.ctrl_action = ACT_RESTART;
                  end else if (byte_idx >= left_q) begin
                     r.ctrl_action = ACT_STOP;
                     busy_q = 1'b0;
                     r.master_done = 1'b1;
                  end else begin
                     r.tx_valid = 1'b1;
                     r.tx_byte = byte_store[SEL_MASTER_TX][byte_idx % BUF_DEPTH];
                     byte_idx = byte_idx + 8'd1;
                  end
               end
               ST_MR_SLA_ACK: begin
                  r.ctrl_action = (byte_idx >= left_q) ? ACT_NACK : ACT_ACK;
               end
               ST_MR_DATA_ACK: begin
                  byte_store[SEL_MASTER_RX][byte_idx % BUF_DEPTH] = w.rx_byte;
                  byte_idx = byte_idx + 8'd1;
                  r.ctrl_action = (byte_idx >= left_q) ? ACT_NACK : ACT_ACK;
               end
               ST_MR_DATA_NAK: begin
                  byte_store[SEL_MASTER_RX][byte_idx % BUF_DEPTH] = w.rx_byte;
                  byte_idx = byte_idx + 8'd1;
                  r.ctrl_action = ACT_STOP;
                  busy_q = 1'b0;
                  r.master_done = 1'b1;
               end
               ST_ARB_LOST: begin
                  busy_q = 1'b0;
               end
               // nack, bus error, no-information and anything unknown
               default: begin
                  r.ctrl_action = ACT_STOP;
                  busy_q = 1'b0;
                  r.error_pulse = 1'b1;
               end
            endcase
         end
         default: begin
         end
      endcase
      r.busy_res = busy_q;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // sample both channels and the register port at each rising edge
   always @(posedge clock) begin : monitor
      bus_request_type  w;
      bus_response_type want;
      if (reset) begin
         tx_wrap = '0;
         rx_wrap = '0;
         busy_q = 1'b0;
         byte_idx = '0;
         index_pending = 1'b0;
         addr_rw = '0;
         reg_q = '0;
         left_q = '0;
         expected_responses.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SLAVE_TX_SIZE: tx_wrap = csr_wdata;
               CSR_SLAVE_RX_SIZE: rx_wrap = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            w = {req_cmd, req_target_addr, req_reg_addr, req_xfer_length, req_status_code,
                 req_rx_byte, req_buf_select, req_buf_index, req_buf_data};
            expected_responses.push_back(sequencer_response(w));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               $display("%0t: response word with none expected, actual action %0h",
                        $time, rsp_ctrl_action);
               errors++;
            end else begin
               want = expected_responses.pop_front();
               check_field("ctrl_action", 8'(want.ctrl_action), 8'(rsp_ctrl_action));
               check_field("tx_valid", 8'(want.tx_valid), 8'(rsp_tx_valid));
               check_field("tx_byte", want.tx_byte, rsp_tx_byte);
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_busy_res));
               check_field("master_done", 8'(want.master_done), 8'(rsp_master_done));
               check_field("slave_done", 8'(want.slave_done), 8'(rsp_slave_done));
               check_field("error_pulse", 8'(want.error_pulse), 8'(rsp_error_pulse));
               check_field("read_data", want.read_data, rsp_read_data);
            end
         end
      end
      fail_count <= errors;
      pending_count <= expected_responses.size();
   end

endmodule

// ===== dv/tb_i2c_transaction_sequencer.sv =====
// stimulus and verdict for the transaction sequencer; checking lives in its_checker
module tb_i2c_transaction_sequencer;
   import its_pkg::*;

   // status codes the block treats as faults, divided by eight
   localparam logic [4:0] ST_BUS_ERROR   = 5'h00;
   localparam logic [4:0] ST_MT_SLA_NAK  = 5'h04;
   localparam logic [4:0] ST_MT_DATA_NAK = 5'h06;
   localparam logic [4:0] ST_MR_SLA_NAK  = 5'h09;
   localparam logic [4:0] ST_SR_DATA_NAK = 5'h11;
   localparam logic [4:0] ST_SR_GEN_NAK  = 5'h13;
   localparam logic [4:0] ST_NO_INFO     = 5'h1F;
   localparam logic [4:0] FAULT_CODES [7] = '{ST_BUS_ERROR, ST_MT_SLA_NAK, ST_MT_DATA_NAK,
                                              ST_MR_SLA_NAK, ST_SR_DATA_NAK, ST_SR_GEN_NAK,
                                              ST_NO_INFO};
   localparam logic [4:0] SR_ADDR_CODES [4] = '{ST_SR_SLA_0, ST_SR_SLA_1, ST_SR_GEN_0,
                                                ST_SR_GEN_1};
   localparam logic [2:0] CMD_SPARE_LAST = 3'd7;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_WORDS   = 400;
   localparam int PHASES         = 8;
   localparam int PHASE_WORDS    = RANDOM_WORDS / PHASES;
   localparam int TX_SIZES [PHASES] = '{1, 511, 3, 255, 0, 256, 2, 0};
   localparam int RX_SIZES [PHASES] = '{2, 256, 5, 0, 511, 1, 7, 0};

   typedef struct packed {
      logic [2:0] cmd;
      logic [6:0] target_addr;
      logic [7:0] reg_addr;
      logic [7:0] xfer_length;
      logic [4:0] status_code;
      logic [7:0] rx_byte;
      logic [1:0] buf_select;
      logic [7:0] buf_index;
      logic [7:0] buf_data;
   } bus_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [2:0]           req_cmd = '0;
   logic [6:0]           req_target_addr = '0;
   logic [7:0]           req_reg_addr = '0;
   logic [7:0]           req_xfer_length = '0;
   logic [4:0]           req_status_code = '0;
   logic [7:0]           req_rx_byte = '0;
   logic [1:0]           req_buf_select = '0;
   logic [7:0]           req_buf_index = '0;
   logic [7:0]           req_buf_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [2:0]           rsp_ctrl_action;
   logic                 rsp_tx_valid;
   logic [7:0]           rsp_tx_byte;
   logic                 rsp_busy_res;
   logic                 rsp_master_done;
   logic                 rsp_slave_done;
   logic                 rsp_error_pulse;
   logic [7:0]           rsp_read_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SLAVE_TX_SIZE;
   logic [SIZE_W-1:0]    csr_wdata = '0;
   int                   fail_count;
   int                   pending_count;

   int           words_sent = 0;
   int           send_streak = 0;
   int           recv_streak = 0;
   bus_word_type plan[$];

   i2c_transaction_sequencer i_dut (.*);
   its_checker i_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // idle cycles before the next word, with occasional stretches of none
   function automatic int draw_gap(inout int streak);
      if (streak > 0) begin
         streak--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) streak = $urandom_range(10, 40);
      return $urandom_range(0, 10);
   endfunction

   function automatic bus_word_type any_word();
      logic [63:0]  noise;
      bus_word_type w;
      noise = {$urandom, $urandom};
      w = noise[$bits(bus_word_type)-1:0];
      // random reads stay on the transmit buffers, which are always filled
      if (w.cmd == CMD_READ) w.buf_select[0] = 1'b0;
      return w;
   endfunction

   function automatic bus_word_type status_word(input logic [4:0] code);
      bus_word_type w;
      w = any_word();
      w.cmd = CMD_STATUS;
      w.status_code = code;
      return w;
   endfunction

   function automatic bus_word_type start_word(input logic [2:0] cmd, input logic [7:0] len);
      bus_word_type w;
      w = any_word();
      w.cmd = cmd;
      w.xfer_length = len;
      return w;
   endfunction

   function automatic bus_word_type buffer_word(input logic [2:0] cmd, input logic [1:0] sel,
                                                input logic [7:0] idx, input logic [7:0] data);
      bus_word_type w;
      w = any_word();
      w.cmd = cmd;
      w.buf_select = sel;
      w.buf_index = idx;
      w.buf_data = data;
      return w;
   endfunction

   // mostly short transfers, now and then long ones
   function automatic int draw_length();
      int r;
      r = $urandom_range(0, 79);
      if (r == 0) return 255;
      if (r < 6) return $urandom_range(7, 40);
      return $urandom_range(0, 6);
   endfunction

   // slave index byte, mostly near the wrap points of small sizes
   function automatic logic [7:0] pick_index();
      return 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 9));
   endfunction

   // present one request word and hold it until accepted
   task automatic send_word(input bus_word_type w);
      int gap;
      gap = draw_gap(send_streak);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= w.cmd;
      req_target_addr <= w.target_addr;
      req_reg_addr <= w.reg_addr;
      req_xfer_length <= w.xfer_length;
      req_status_code <= w.status_code;
      req_rx_byte <= w.rx_byte;
      req_buf_select <= w.buf_select;
      req_buf_index <= w.buf_index;
      req_buf_data <= w.buf_data;
      do @(posedge clock); while (!req_ready);
      if (w.cmd <= CMD_READ) words_sent++;
   endtask

   // stop sending until every predicted response word has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side back-pressure
   initial begin : result_sink
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(recv_streak);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ends the run when no word moves on either channel for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      bus_word_type w;
      int           len;
      int           k;
      int           tx_size;
      int           rx_size;
      int           phase_start;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // fill both transmit buffers, the only ones the block reads by itself
      for (int idx = 0; idx < BUF_DEPTH; idx++) begin
         send_word(buffer_word(CMD_LOAD, SEL_MASTER_TX, 8'(idx), 8'($urandom_range(0, 255))));
         send_word(buffer_word(CMD_LOAD, SEL_SLAVE_TX, 8'(idx), 8'($urandom_range(0, 255))));
      end

      // unused commands only report busy
      for (int c = CMD_READ + 1; c <= CMD_SPARE_LAST; c++) begin
         w = any_word();
         w.cmd = 3'(c);
         send_word(w);
      end

      // buffer load and read-back at the index extremes
      send_word(buffer_word(CMD_LOAD, SEL_MASTER_TX, 8'hFF, 8'h00));
      send_word(buffer_word(CMD_READ, SEL_MASTER_TX, 8'hFF, 8'h00));
      send_word(buffer_word(CMD_LOAD, SEL_SLAVE_RX, 8'h00, 8'hFF));
      send_word(buffer_word(CMD_READ, SEL_SLAVE_RX, 8'h00, 8'hFF));

      // start while busy, then a read of length zero
      w = start_word(CMD_START_WR, 8'd255);
      w.target_addr = 7'h7F;
      w.reg_addr = 8'hFF;
      send_word(w);
      w = start_word(CMD_START_RD, 8'd0);
      w.target_addr = '0;
      w.reg_addr = '0;
      send_word(w);
      send_word(status_word(ST_START));
      send_word(status_word(ST_MT_SLA_ACK));
      send_word(status_word(ST_MT_DATA_ACK));
      send_word(status_word(ST_RESTART));
      // repeated start with no count left
      send_word(status_word(ST_RESTART));
      send_word(status_word(ST_MR_SLA_ACK));
      send_word(status_word(ST_MR_DATA_NAK));

      // bus error, no-information code, arbitration lost
      send_word(status_word(ST_BUS_ERROR));
      send_word(status_word(ST_NO_INFO));
      send_word(status_word(ST_ARB_LOST));

      // general call receive with index and data extremes
      send_word(status_word(ST_SR_GEN_0));
      w = status_word(ST_SR_GEN_DATA);
      w.rx_byte = 8'hFF;
      send_word(w);
      w.rx_byte = 8'h00;
      send_word(w);
      send_word(status_word(ST_SR_STOP));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         tx_size = (p == PHASES - 1) ? $urandom_range(0, 2**SIZE_W - 1) : TX_SIZES[p];
         rx_size = (p == PHASES - 1) ? $urandom_range(0, 2**SIZE_W - 1) : RX_SIZES[p];

         // new buffer sizes while the block is idle
         csr_wr_en <= 1'b1;
         csr_index <= CSR_SLAVE_TX_SIZE;
         csr_wdata <= SIZE_W'(tx_size);
         @(posedge clock);
         csr_index <= CSR_SLAVE_RX_SIZE;
         csr_wdata <= SIZE_W'(rx_size);
         @(posedge clock);
         csr_wr_en <= 1'b0;

         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            case ($urandom_range(0, 9))
               // master register write
               0, 1: begin
                  len = draw_length();
                  plan.push_back(start_word(CMD_START_WR, 8'(len)));
                  plan.push_back(status_word(ST_START));
                  plan.push_back(status_word(ST_MT_SLA_ACK));
                  repeat (len + 1) plan.push_back(status_word(ST_MT_DATA_ACK));
               end
               // master register read
               2, 3: begin
                  len = draw_length();
                  plan.push_back(start_word(CMD_START_RD, 8'(len)));
                  plan.push_back(status_word(ST_START));
                  plan.push_back(status_word(ST_MT_SLA_ACK));
                  plan.push_back(status_word(ST_MT_DATA_ACK));
                  plan.push_back(status_word(ST_RESTART));
                  plan.push_back(status_word(ST_MR_SLA_ACK));
                  repeat (((len == 0) ? 1 : len) - 1) plan.push_back(status_word(ST_MR_DATA_ACK));
                  plan.push_back(status_word(ST_MR_DATA_NAK));
               end
               // slave receive: index then data words
               4, 5: begin
                  k = $urandom_range(0, 3);
                  plan.push_back(status_word(SR_ADDR_CODES[k]));
                  w = status_word((k >= 2) ? ST_SR_GEN_DATA : ST_SR_DATA);
                  w.rx_byte = pick_index();
                  plan.push_back(w);
                  repeat ($urandom_range(0, 8)) begin
                     plan.push_back(status_word((k >= 2) ? ST_SR_GEN_DATA : ST_SR_DATA));
                  end
                  plan.push_back(status_word(ST_SR_STOP));
               end
               // slave transmit after an index write
               6, 7: begin
                  plan.push_back(status_word($urandom_range(0, 1) ? ST_SR_SLA_1 : ST_SR_SLA_0));
                  w = status_word(ST_SR_DATA);
                  w.rx_byte = pick_index();
                  plan.push_back(w);
                  plan.push_back(status_word($urandom_range(0, 1) ? ST_ST_ARB_SLA : ST_ST_SLA));
                  repeat ($urandom_range(0, 6)) plan.push_back(status_word(ST_ST_DATA_ACK));
                  plan.push_back(status_word($urandom_range(0, 1) ? ST_ST_LAST : ST_ST_DATA_NAK));
                  if ($urandom_range(0, 1)) plan.push_back(status_word(ST_SR_STOP));
               end
               // fully random words
               default: begin
                  repeat ($urandom_range(1, 3)) plan.push_back(any_word());
               end
            endcase

            // now and then cut the transfer short, inject a fault or lose arbitration
            if (plan.size() > 1 && $urandom_range(0, 5) == 0) begin
               k = $urandom_range(1, plan.size() - 1);
               case ($urandom_range(0, 2))
                  0: begin
                     while (plan.size() > k) void'(plan.pop_back());
                  end
                  1: begin
                     plan[k].cmd = CMD_STATUS;
                     plan[k].status_code = FAULT_CODES[$urandom_range(0, 6)];
                  end
                  default: begin
                     plan.insert(k, status_word(ST_ARB_LOST));
                  end
               endcase
            end

            foreach (plan[i]) send_word(plan[i]);
            plan.delete();
         end
         drain();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
